// ===== hw/rtl/cdv_pkg.sv =====
// ----------------------------------------------------------------------------
// cdv_pkg
// Shared types and constants for the CPF check digit validator pipeline.
// ----------------------------------------------------------------------------
package cdv_pkg;

    localparam int ID_W        = 37;
    localparam int BIN_W       = 40;              // ID padded to whole dabble stages
    localparam int STEPS_PER_ST = 8;
    localparam int DD_STAGES   = BIN_W / STEPS_PER_ST;
    localparam int NDIG        = 11;
    localparam int BCD_W       = 4 * NDIG;
    localparam int SUM_W       = 10;              // max weighted sum is 585
    localparam int N_STAGES    = DD_STAGES + 3;   // dabble, sums, mod 11, check
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    localparam logic [ID_W-1:0] ID_LIMIT = 37'd100000000000;

    localparam logic [1:0] ST_INVALID = 2'd0;
    localparam logic [1:0] ST_VALID   = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
        logic             oor;
    } t_dd;

    typedef struct packed {
        logic [SUM_W-1:0] s1;
        logic [SUM_W-1:0] s2;
        logic [3:0]       d10;
        logic [3:0]       d11;
        logic             oor;
    } t_sum;

    typedef struct packed {
        logic [3:0] r1;
        logic [3:0] r2;
        logic [3:0] d10;
        logic [3:0] d11;
        logic       oor;
    } t_rem;

    typedef struct packed {
        logic [3:0] c2;
        logic [3:0] c1;
        logic [1:0] status;
    } t_res;

endpackage

// ===== hw/rtl/cpf_check_digit_validator_top.sv =====
// Throughput: one item per cycle unless m_axis_tready stalls the pipeline; five
// binary-to-BCD stages of eight steps, then weighted sums, modulo 11 and check stages, each a register stage.
// A stalled stage frees as soon as the stage after it moves (bubbles collapse).
// Reset (i_rst_n low, synchronous) clears all stage valid bits; no data is kept.
// ----------------------------------------------------------------------------
// cpf_check_digit_validator_top
// Validates an 11-digit CPF identity number and reports both check digits.
// ----------------------------------------------------------------------------
module cpf_check_digit_validator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cdv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [36:0] id_number
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [cdv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata    // [1:0] status,
                                                              // [5:2] first_check_digit,
                                                              // [9:6] second_check_digit
);
    import cdv_pkg::*;

    logic [N_STAGES-1:0] stage_valid;
    logic [N_STAGES-1:0] stage_rdy;
    t_dd                 dd_bus [DD_STAGES+1];
    logic [DD_STAGES:0]  dd_valid;
    t_sum                sum_data;
    t_rem                rem_data;
    t_res                res_data;
    logic [ID_W-1:0]     id_number;

    assign id_number  = s_axis_tdata[ID_W-1:0];
    assign dd_bus[0].bin = BIN_W'(id_number);
    assign dd_bus[0].bcd = '0;
    assign dd_bus[0].oor = (id_number >= ID_LIMIT);
    assign dd_valid[0]   = s_axis_tvalid;

    // a stage takes new data when it is empty or its content moves on
    always_comb begin
        stage_rdy[N_STAGES-1] = !stage_valid[N_STAGES-1] || m_axis_tready;
        for (int k = N_STAGES-2; k >= 0; k--) begin
            stage_rdy[k] = !stage_valid[k] || stage_rdy[k+1];
        end
    end

    assign s_axis_tready = stage_rdy[0];

    for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
        cdv_dabble_stage u_dd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (stage_rdy[g]),
            .i_valid (dd_valid[g]),
            .i_data  (dd_bus[g]),
            .o_valid (dd_valid[g+1]),
            .o_data  (dd_bus[g+1])
        );
        assign stage_valid[g] = dd_valid[g+1];
    end

    cdv_wsum_stage u_wsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (stage_rdy[DD_STAGES]),
        .i_valid (dd_valid[DD_STAGES]),
        .i_data  (dd_bus[DD_STAGES]),
        .o_valid (stage_valid[DD_STAGES]),
        .o_data  (sum_data)
    );

    cdv_mod11_stage u_mod11 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (stage_rdy[DD_STAGES+1]),
        .i_valid (stage_valid[DD_STAGES]),
        .i_data  (sum_data),
        .o_valid (stage_valid[DD_STAGES+1]),
        .o_data  (rem_data)
    );

    cdv_check_stage u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (stage_rdy[DD_STAGES+2]),
        .i_valid (stage_valid[DD_STAGES+1]),
        .i_data  (rem_data),
        .o_valid (stage_valid[DD_STAGES+2]),
        .o_data  (res_data)
    );

    assign m_axis_tvalid = stage_valid[N_STAGES-1];
    assign m_axis_tdata  = OUT_TDATA_W'(res_data);

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res_data.status == ST_RANGE) |-> (res_data.c1 == 4'd0 &&
        res_data.c2 == 4'd0))
        else $error("out of range result carries nonzero check digits");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res_data.c1 <= 4'd9 && res_data.c2 <= 4'd9))
        else $error("check digit above 9");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (stage_valid == '0))
        else $error("pipeline holds valid data after reset");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&stage_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while pipeline full and stalled");

endmodule

// ===== hw/rtl/cdv_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// cdv_dabble_stage
// Eight shift-and-add-3 steps of binary to BCD conversion, registered.
// ----------------------------------------------------------------------------
module cdv_dabble_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic          i_valid,
    input  cdv_pkg::t_dd  i_data,
    output logic          o_valid,
    output cdv_pkg::t_dd  o_data
);
    import cdv_pkg::*;

    logic r_valid;
    t_dd  r_data;
    t_dd  n_data;

    always_comb begin
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
        bcd = i_data.bcd;
        bin = i_data.bin;
        for (int s = 0; s < STEPS_PER_ST; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (bcd[4*d +: 4] >= 4'd5) begin
                    bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
                end
            end
            {bcd, bin} = {bcd[BCD_W-2:0], bin, 1'b0};
        end
        n_data.bcd = bcd;
        n_data.bin = bin;
        n_data.oor = i_data.oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
        if (i_load && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/cdv_wsum_stage.sv =====
// ----------------------------------------------------------------------------
// cdv_wsum_stage
// Weighted digit sums for both check digits, registered.
// ----------------------------------------------------------------------------
module cdv_wsum_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic          i_valid,
    input  cdv_pkg::t_dd  i_data,
    output logic          o_valid,
    output cdv_pkg::t_sum o_data
);
    import cdv_pkg::*;

    logic r_valid;
    t_sum r_data;
    t_sum n_data;

    // digit k (1 = most significant) sits at bcd[4*(11-k) +: 4]
    always_comb begin
        logic [SUM_W-1:0] s1;
        logic [SUM_W-1:0] s2;
        logic [3:0]       dk;
        s1 = '0;
        s2 = '0;
        for (int k = 1; k <= 10; k++) begin
            dk = i_data.bcd[4*(NDIG-k) +: 4];
            if (k <= 9) begin
                s1 = s1 + SUM_W'(dk) * SUM_W'(11 - k);
            end
            s2 = s2 + SUM_W'(dk) * SUM_W'(12 - k);
        end
        n_data.s1  = s1;
        n_data.s2  = s2;
        n_data.d10 = i_data.bcd[7:4];
        n_data.d11 = i_data.bcd[3:0];
        n_data.oor = i_data.oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
        if (i_load && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/cdv_mod11_stage.sv =====
// ----------------------------------------------------------------------------
// cdv_mod11_stage
// Remainder of both weighted sums modulo 11, registered.
// ----------------------------------------------------------------------------
module cdv_mod11_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic          i_valid,
    input  cdv_pkg::t_sum i_data,
    output logic          o_valid,
    output cdv_pkg::t_rem o_data
);
    import cdv_pkg::*;

    logic r_valid;
    t_rem r_data;
    t_rem n_data;

    // q = floor(s*373/4096) never overshoots s/11 for s <= 585; one fixup
    function automatic logic [3:0] mod11(input logic [SUM_W-1:0] s);
        logic [18:0]      prod;
        logic [6:0]       q;
        logic [SUM_W-1:0] qx11;
        logic [SUM_W-1:0] rm;
        prod = 19'(s) * 19'd373;
        q    = prod[18:12];
        qx11 = (SUM_W'(q) << 3) + (SUM_W'(q) << 1) + SUM_W'(q);
        rm   = s - qx11;
        if (rm >= SUM_W'(11)) begin
            rm = rm - SUM_W'(11);
        end
        return rm[3:0];
    endfunction

    always_comb begin
        n_data.r1  = mod11(i_data.s1);
        n_data.r2  = mod11(i_data.s2);
        n_data.d10 = i_data.d10;
        n_data.d11 = i_data.d11;
        n_data.oor = i_data.oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
        if (i_load && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/cdv_check_stage.sv =====
// ----------------------------------------------------------------------------
// cdv_check_stage
// Check digits from remainders, digit compare and status; output register.
// ----------------------------------------------------------------------------
module cdv_check_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic          i_valid,
    input  cdv_pkg::t_rem i_data,
    output logic          o_valid,
    output cdv_pkg::t_res o_data
);
    import cdv_pkg::*;

    logic       r_valid;
    t_res       r_data;
    t_res       n_data;
    logic [3:0] c1;
    logic [3:0] c2;

    // (10*S) mod 11 = (11 - S mod 11) mod 11; a value of 10 (S mod 11 == 1) maps to 0
    always_comb begin
        c1 = (i_data.r1 <= 4'd1) ? 4'd0 : 4'd11 - i_data.r1;
        c2 = (i_data.r2 <= 4'd1) ? 4'd0 : 4'd11 - i_data.r2;
        if (i_data.oor) begin
            n_data.status = ST_RANGE;
            n_data.c1     = 4'd0;
            n_data.c2     = 4'd0;
        end else begin
            n_data.status = (i_data.d10 == c1 && i_data.d11 == c2) ? ST_VALID : ST_INVALID;
            n_data.c1     = c1;
            n_data.c2     = c2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
        if (i_load && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
